### rtl/blvs_pkg.sv
// ----------------------------------------------------------------------------
// blvs_pkg
// Shared types and constants of the binary line vote search core.
// ----------------------------------------------------------------------------
package blvs_pkg;

  // default image store size
  localparam int unsigned DEF_MAX_COLS = 320;
  localparam int unsigned DEF_MAX_ROWS = 256;

  // field and register widths
  localparam int unsigned REG_W     = 9;
  localparam int unsigned ROW_W     = 8;
  localparam int unsigned COL_W     = 9;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned VOTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // signed line arithmetic and divider widths
  localparam int unsigned SX_W  = 12;
  localparam int unsigned DIV_W = 10;
  localparam int unsigned CMP_W = REG_W + 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd1;

  localparam logic [REG_W-1:0] RESET_ROWS = 9'd240;
  localparam logic [REG_W-1:0] RESET_COLS = 9'd320;

  // item actions
  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_SEARCH = 1'b1;

  // candidate range: left side runs while 10*i < 6*cols, right side from
  // floor(3*cols/10); the division by ten is a reciprocal multiply
  localparam int unsigned CAND_NUM    = 6;
  localparam int unsigned CAND_DEN    = 10;
  localparam int unsigned START_NUM   = 3;
  localparam int unsigned RECIP_TENTH = 6554;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned MIN_ROWS    = 3;

  localparam logic [VOTE_W-1:0] VOTE_MAX = 8'd255;

  typedef struct packed {
    logic             action;
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic [VAL_W-1:0] pixel_value;
    logic [COL_W-1:0] bottom_col;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  top_col;
    logic [VOTE_W-1:0] vote_count;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [REG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [REG_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_PIX,
    ST_CAND,
    ST_FINISH
  } state_e;

endpackage

### rtl/blvs_bitmem.sv
// ----------------------------------------------------------------------------
// blvs_bitmem
// One-bit image store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module blvs_bitmem #(
  parameter int unsigned DEPTH = blvs_pkg::DEF_MAX_ROWS * blvs_pkg::DEF_MAX_COLS,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic              wr_bit_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic              rd_bit_o
);

  logic mem_q [DEPTH];
  logic rd_bit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_bit_i;
    end
    if (re_i) begin
      rd_bit_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_bit_o = rd_bit_q;

endmodule

### rtl/blvs_divider.sv
// ----------------------------------------------------------------------------
// blvs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module blvs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blvs_pkg::div_req_t req_i,
  output blvs_pkg::div_rsp_t rsp_o
);
  import blvs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [REG_W-1:0] rem_q, rem_d;
  logic [REG_W-1:0] den_q, den_d;
  logic [REG_W:0]   rem_sh;
  logic [REG_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, num_q[DIV_W-1]};
    fits    = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(DIV_W);
      num_d = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
    end else if (run_q) begin
      // quotient bits shift in where dividend bits leave
      num_d = {num_q[DIV_W-2:0], fits};
      rem_d = fits ? rem_sub[REG_W-1:0] : rem_sh[REG_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

### rtl/binary_line_vote_search_core.sv
// ----------------------------------------------------------------------------
// binary_line_vote_search_core
// Stores a one-bit image and finds the best voted line from a bottom column.
// ----------------------------------------------------------------------------
//  channel   direction  signals                              handshake
//  item      in         start_i, busy_o, item_i              start_i & !busy_o
//  result    out        done_o, result_o                     done_o, one cycle
//  config    in         cfg_we_i, cfg_idx_i, cfg_data_i      cfg_we_i
//
//  a load item writes one bit; loads run back to back.
//  a search walks rows - 2 line points per candidate; each line point reads
//  three pixels through the single read port of the image store, and one
//  divider pass runs at the start of the search.
//  reset returns control to idle and sets the configuration to 240 rows and
//  320 columns; the image store is not cleared. the result cannot be stalled:
//  done_o is high for exactly one cycle.
module binary_line_vote_search_core #(
  parameter int unsigned MAX_COLS = blvs_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = blvs_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  blvs_pkg::item_t                    item_i,
  output logic                               busy_o,
  output logic                               done_o,
  output blvs_pkg::result_t                  result_o,
  input  logic                               cfg_we_i,
  input  logic [blvs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [blvs_pkg::REG_W-1:0]         cfg_data_i
);
  import blvs_pkg::*;

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PROD_W = REG_W + 2 + RECIP_W;

  state_e state_q, state_d;

  logic [REG_W-1:0] rows_cfg_q, cols_cfg_q;

  logic [REG_W-1:0]        rows_q, rows_d;
  logic [REG_W-1:0]        cols_q, cols_d;
  logic [COL_W-1:0]        bottom_q, bottom_d;
  logic                    mode_q, mode_d;
  logic [COL_W-1:0]        i_q, i_d;
  logic [REG_W-1:0]        den_q, den_d;
  logic                    neg_q, neg_d;
  logic signed [SX_W-1:0]  dq_q, dq_d;
  logic [REG_W-1:0]        dr_q, dr_d;
  logic signed [SX_W-1:0]  q_q, q_d;
  logic [REG_W-1:0]        rem_q, rem_d;
  logic [REG_W-1:0]        j_q, j_d;
  logic [ADDR_W-1:0]       base_q, base_d;
  logic [1:0]              phase_q, phase_d;
  logic                    ok_q, ok_d;
  logic                    v_q, v_d;
  logic [REG_W-1:0]        votes_q, votes_d;
  logic [REG_W-1:0]        best_q, best_d;
  logic [COL_W-1:0]        best_col_q, best_col_d;

  logic                    accept;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_wr_addr;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_rd_addr;
  logic                    mem_rd_bit;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic [REG_W-1:0]        rows_sat, cols_sat;
  logic [REG_W+1:0]        cols_x3;
  logic [PROD_W-1:0]       third_prod;
  logic [CMP_W-1:0]        six_cols;
  logic [CMP_W-1:0]        ten_i;
  logic [COL_W:0]          i_next;
  logic                    more;
  logic signed [SX_W-1:0]  d0;
  logic signed [SX_W-1:0]  qa;
  logic signed [SX_W-1:0]  x_pos;
  logic signed [SX_W-1:0]  c_pos;
  logic                    c_ok;
  logic                    pt_ok;
  logic [REG_W:0]          rem_sum;
  logic                    rem_wrap;

  assign accept = start_i && !busy_o;
  assign busy_o = state_q != ST_IDLE;
  assign done_o = state_q == ST_FINISH;

  // pixel loads go straight to the store while no search runs
  assign mem_we = accept && (item_i.action == ACTION_LOAD) &&
                  (32'(item_i.pixel_row) < MAX_ROWS) &&
                  (32'(item_i.pixel_col) < MAX_COLS);
  assign mem_wr_addr = ADDR_W'(32'(item_i.pixel_row) * MAX_COLS + 32'(item_i.pixel_col));

  blvs_bitmem #(
    .DEPTH (DEPTH)
  ) u_bitmem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (mem_wr_addr),
    .wr_bit_i  (item_i.pixel_value != '0),
    .re_i      (mem_re),
    .rd_addr_i (mem_rd_addr),
    .rd_bit_o  (mem_rd_bit)
  );

  blvs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= RESET_ROWS;
      cols_cfg_q <= RESET_COLS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_ROWS: rows_cfg_q <= cfg_data_i;
        CFG_IMAGE_COLS: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_sat   = (32'(rows_cfg_q) > MAX_ROWS) ? REG_W'(MAX_ROWS) : rows_cfg_q;
    cols_sat   = (32'(cols_cfg_q) > MAX_COLS) ? REG_W'(MAX_COLS) : cols_cfg_q;
    cols_x3    = (REG_W+2)'(cols_sat) * (REG_W+2)'(START_NUM);
    third_prod = PROD_W'(cols_x3) * PROD_W'(RECIP_TENTH);
    six_cols   = CMP_W'(cols_q) * CMP_W'(CAND_NUM);
    i_next     = {1'b0, i_q} + 1'b1;
    ten_i      = CMP_W'(i_next) * CMP_W'(CAND_DEN);
    more       = mode_q ? (ten_i < six_cols) : (i_next < {1'b0, bottom_q});
    d0         = $signed(SX_W'(bottom_q)) - $signed(SX_W'(i_q));
    qa         = $signed(SX_W'(div_rsp.quot));
    x_pos      = $signed(SX_W'(i_q)) + q_q;
    c_pos      = x_pos + $signed(SX_W'(phase_q)) - $signed(SX_W'(1));
    c_ok       = (c_pos >= $signed(SX_W'(0))) && (c_pos < $signed(SX_W'(cols_q)));
    pt_ok      = ok_q && v_q && mem_rd_bit;
    rem_sum    = {1'b0, rem_q} + {1'b0, dr_q};
    rem_wrap   = rem_sum >= {1'b0, den_q};

    mem_re      = (state_q == ST_PIX) && (phase_q != 2'd3) && c_ok;
    mem_rd_addr = ADDR_W'(({1'b0, base_q} + (ADDR_W+1)'($unsigned(c_pos))));

    div_req.start = 1'b0;
    div_req.num   = neg_d ? DIV_W'(-d0) : DIV_W'(d0);
    div_req.den   = den_q;

    state_d    = state_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    bottom_d   = bottom_q;
    mode_d     = mode_q;
    i_d        = i_q;
    den_d      = den_q;
    neg_d      = d0 < $signed(SX_W'(0));
    dq_d       = dq_q;
    dr_d       = dr_q;
    q_d        = q_q;
    rem_d      = rem_q;
    j_d        = j_q;
    base_d     = base_q;
    phase_d    = phase_q;
    ok_d       = ok_q;
    v_d        = mem_re;
    votes_d    = votes_q;
    best_d     = best_q;
    best_col_d = best_col_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.action == ACTION_SEARCH)) begin
          rows_d     = rows_sat;
          cols_d     = cols_sat;
          bottom_d   = item_i.bottom_col;
          mode_d     = {1'b0, item_i.bottom_col, 1'b0} < {2'b0, cols_sat};
          i_d        = ({1'b0, item_i.bottom_col, 1'b0} < {2'b0, cols_sat}) ?
                       COL_W'(1) : COL_W'(third_prod >> RECIP_SHIFT);
          den_d      = rows_sat - REG_W'(2);
          best_d     = '0;
          best_col_d = '0;
          state_d    = (rows_sat < REG_W'(MIN_ROWS)) ? ST_FINISH : ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (mode_q ? !(CMP_W'(CAND_DEN) < six_cols) : !(i_q < bottom_q)) begin
          state_d = ST_FINISH;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        neg_d = neg_q;
        if (div_rsp.done) begin
          // turn the magnitude result into a floor quotient
          if (neg_q && (div_rsp.rem != '0)) begin
            dq_d = -qa - $signed(SX_W'(1));
            dr_d = den_q - div_rsp.rem;
          end else begin
            dq_d = neg_q ? -qa : qa;
            dr_d = div_rsp.rem;
          end
          q_d     = '0;
          rem_d   = '0;
          j_d     = REG_W'(1);
          base_d  = ADDR_W'(MAX_COLS);
          phase_d = 2'd0;
          votes_d = '0;
          state_d = ST_PIX;
        end
      end
      ST_PIX: begin
        neg_d = neg_q;
        // phase 0..2 issue left, center, right; data lands one phase later
        if (phase_q == 2'd0) begin
          ok_d = 1'b1;
        end else begin
          ok_d = pt_ok;
        end
        phase_d = phase_q + 1'b1;
        if (phase_q == 2'd3) begin
          if (pt_ok) begin
            votes_d = votes_q + 1'b1;
          end
          if (j_q == den_q) begin
            state_d = ST_CAND;
          end else begin
            j_d    = j_q + 1'b1;
            base_d = base_q + ADDR_W'(MAX_COLS);
            rem_d  = rem_wrap ? REG_W'(rem_sum - {1'b0, den_q}) : rem_sum[REG_W-1:0];
            q_d    = q_q + dq_q + (rem_wrap ? $signed(SX_W'(1)) : $signed(SX_W'(0)));
          end
        end
      end
      ST_CAND: begin
        neg_d = neg_q;
        if (votes_q > best_q) begin
          best_d     = votes_q;
          best_col_d = i_q;
        end
        if (!more) begin
          state_d = ST_FINISH;
        end else begin
          // next candidate moves the line offset down by one
          i_d = i_next[COL_W-1:0];
          if (dr_q == '0) begin
            dr_d = den_q - REG_W'(1);
            dq_d = dq_q - $signed(SX_W'(1));
          end else begin
            dr_d = dr_q - REG_W'(1);
          end
          q_d     = '0;
          rem_d   = '0;
          j_d     = REG_W'(1);
          base_d  = ADDR_W'(MAX_COLS);
          phase_d = 2'd0;
          votes_d = '0;
          state_d = ST_PIX;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q     <= rows_d;
    cols_q     <= cols_d;
    bottom_q   <= bottom_d;
    mode_q     <= mode_d;
    i_q        <= i_d;
    den_q      <= den_d;
    neg_q      <= neg_d;
    dq_q       <= dq_d;
    dr_q       <= dr_d;
    q_q        <= q_d;
    rem_q      <= rem_d;
    j_q        <= j_d;
    base_q     <= base_d;
    phase_q    <= phase_d;
    ok_q       <= ok_d;
    v_q        <= v_d;
    votes_q    <= votes_d;
    best_q     <= best_d;
    best_col_q <= best_col_d;
  end

  assign result_o.top_col    = best_col_q;
  assign result_o.vote_count = (best_q > REG_W'(VOTE_MAX)) ? VOTE_MAX : best_q[VOTE_W-1:0];

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.action == ACTION_SEARCH)) |=> busy_o)
    else $error("search item accepted without going busy");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX) |-> ((rem_q < den_q) && (dr_q < den_q)))
    else $error("line remainder out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX) |-> ((j_q != '0) && (j_q <= den_q)))
    else $error("line row out of range");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

endmodule
